// ----- sv/scim_pkg.sv -----
// Shared constants for the scanline IRQ counter and bank mapper.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package scim_pkg;

  localparam int AddrWidth      = 16;
  localparam int DataWidth      = 8;
  localparam int CounterWidth   = 16;
  localparam int SlotWidth      = 9;
  localparam int PageCountWidth = 10;
  localparam int BankWidth      = 8;

  // Configuration port.
  localparam int ApbAddrWidth = 3;
  localparam int ApbDataWidth = 32;
  localparam logic [0:0] RegPageCount = 1'b0;
  localparam logic [PageCountWidth-1:0] PageCountReset = PageCountWidth'(16);

  // Request kinds.
  localparam logic ReqCpuWrite = 1'b0;
  localparam logic ReqTick     = 1'b1;

  // CPU register addresses, matched exactly.
  localparam logic [AddrWidth-1:0] AddrNibble0 = 16'h8000;
  localparam logic [AddrWidth-1:0] AddrNibble1 = 16'h9000;
  localparam logic [AddrWidth-1:0] AddrNibble2 = 16'hA000;
  localparam logic [AddrWidth-1:0] AddrNibble3 = 16'hB000;
  localparam logic [AddrWidth-1:0] AddrEnable  = 16'hC000;
  localparam logic [AddrWidth-1:0] AddrBank    = 16'hF000;

  localparam int EnableBit = 1;

  localparam logic [CounterWidth-1:0] TickStep  = CounterWidth'(114);
  localparam logic [CounterWidth-1:0] FireLimit = CounterWidth'(16'hFFFF - 114);

endpackage

`default_nettype wire

// ----- sv/scim_if.sv -----
// Valid/ready channel interfaces for mapper requests and results.
// Depends on scim_pkg for the field widths.
`default_nettype none

interface scim_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [scim_pkg::AddrWidth-1:0] addr;
  logic [scim_pkg::DataWidth-1:0] data;

  modport source (output valid, req_type, addr, data, input ready);
  modport sink   (input valid, req_type, addr, data, output ready);
endinterface

interface scim_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              irq_fire;
  logic [scim_pkg::SlotWidth-1:0]    page_low_slot;
  logic [scim_pkg::SlotWidth-1:0]    page_high_slot;
  logic [scim_pkg::CounterWidth-1:0] counter_now;

  modport source (output valid, irq_fire, page_low_slot, page_high_slot, counter_now,
                  input ready);
  modport sink   (input valid, irq_fire, page_low_slot, page_high_slot, counter_now,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/scim_moddiv.sv -----
// Iterative restoring remainder unit: one dividend bit per cycle.
// Gives the low page slot and the following slot modulo the divisor. Uses scim_pkg.
`default_nettype none

module scim_moddiv (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [scim_pkg::SlotWidth-1:0]      dividend,
  input  logic [scim_pkg::PageCountWidth-1:0] divisor,
  output logic                                done,
  output logic [scim_pkg::SlotWidth-1:0]      rem_low,
  output logic [scim_pkg::SlotWidth-1:0]      rem_high
);
  import scim_pkg::*;

  localparam int StepWidth = $clog2(SlotWidth + 1);

  logic [PageCountWidth-1:0] rem;
  logic [SlotWidth-1:0]      quo;
  logic [StepWidth-1:0]      cnt;
  logic                      busy;

  logic [PageCountWidth:0]   trial;
  logic [PageCountWidth:0]   diff;
  logic                      fits;
  logic [PageCountWidth-1:0] inc;

  assign trial = {rem, quo[SlotWidth-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        cnt  <= StepWidth'(SlotWidth);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? diff[PageCountWidth-1:0] : trial[PageCountWidth-1:0];
        quo <= {quo[SlotWidth-2:0], 1'b0};
        cnt <= cnt - StepWidth'(1);
        if (cnt == StepWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend is even and below 512, so the remainder fits the slot width,
  // and the next slot is the remainder plus one, wrapping at the divisor.
  assign rem_low  = rem[SlotWidth-1:0];
  assign inc      = {1'b0, rem_low} + PageCountWidth'(1);
  assign rem_high = (inc == divisor) ? '0 : inc[SlotWidth-1:0];

endmodule

`default_nettype wire

// ----- sv/scanline_irq_counter_bank_mapper_top.sv -----
// Top level of the scanline IRQ counter and bank mapper.
// Depends on scim_pkg, scim_if.sv and scim_moddiv.
`default_nettype none

// Each request is a CPU register write or a scanline tick and gives one result.
// The register or counter update is applied at the edge of the request transfer.
// That same edge starts the bit-serial remainder unit, which reduces twice the
// bank number modulo the page count. When the remainder is done, the second page
// slot is formed from it and the output register is loaded. The request side
// is ready again once the result is in the output register. A new request can
// therefore start while the previous result still waits. If the previous result
// is still waiting when the next remainder is done, the block holds until the
// output register frees up. The page count register must be written over the APB
// port only while no request is in flight; the block itself does not enforce this.
// A page count of zero acts as one.
module scanline_irq_counter_bank_mapper_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [scim_pkg::ApbAddrWidth-1:0] paddr,
  input  logic [scim_pkg::ApbDataWidth-1:0] pwdata,
  output logic [scim_pkg::ApbDataWidth-1:0] prdata,
  output logic                              pready,
  scim_req_if.sink                          req,
  scim_rsp_if.source                        rsp
);
  import scim_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t                    state;
  logic [PageCountWidth-1:0] page_count;
  logic [CounterWidth-1:0]   irq_count;
  logic                      irq_enable;
  logic [BankWidth-1:0]      bank_select;
  logic                      fire_pend;

  logic [CounterWidth-1:0]   irq_count_next;
  logic                      irq_enable_next;
  logic [BankWidth-1:0]      bank_select_next;
  logic                      fire_next;

  logic                      accept;
  logic                      cfg_write;
  logic                      div_done;
  logic [PageCountWidth-1:0] divisor;
  logic [SlotWidth-1:0]      slot_low;
  logic [SlotWidth-1:0]      slot_high;
  logic                      out_free;
  logic                      rsp_load;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[ApbAddrWidth-1] == RegPageCount);
  assign prdata    = (paddr[ApbAddrWidth-1] == RegPageCount)
                     ? ApbDataWidth'(page_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= PageCountReset;
    end else if (cfg_write) begin
      page_count <= pwdata[PageCountWidth-1:0];
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign rsp_load  = ((state == ST_DIV && div_done) || state == ST_HOLD) && out_free;

  always_comb begin
    irq_count_next   = irq_count;
    irq_enable_next  = irq_enable;
    bank_select_next = bank_select;
    fire_next        = 1'b0;
    if (req.req_type == ReqCpuWrite) begin
      case (req.addr)
        AddrNibble0: irq_count_next[3:0]   = req.data[3:0];
        AddrNibble1: irq_count_next[7:4]   = req.data[3:0];
        AddrNibble2: irq_count_next[11:8]  = req.data[3:0];
        AddrNibble3: irq_count_next[15:12] = req.data[3:0];
        AddrEnable:  irq_enable_next       = req.data[EnableBit];
        AddrBank:    bank_select_next      = req.data;
        default:     ;
      endcase
    end else if (irq_enable) begin
      // Past the limit the counter would wrap, so it fires instead of advancing.
      if (irq_count > FireLimit) begin
        fire_next       = 1'b1;
        irq_enable_next = 1'b0;
      end else begin
        irq_count_next = irq_count + TickStep;
      end
    end
  end

  assign divisor = (page_count == '0) ? PageCountWidth'(1) : page_count;

  scim_moddiv u_moddiv (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend ({bank_select_next, 1'b0}),
    .divisor  (divisor),
    .done     (div_done),
    .rem_low  (slot_low),
    .rem_high (slot_high)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      irq_count   <= '0;
      irq_enable  <= 1'b0;
      bank_select <= '0;
      fire_pend   <= 1'b0;
      rsp.valid   <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp.valid          <= 1'b1;
        rsp.irq_fire       <= fire_pend;
        rsp.page_low_slot  <= slot_low;
        rsp.page_high_slot <= slot_high;
        rsp.counter_now    <= irq_count;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            irq_count   <= irq_count_next;
            irq_enable  <= irq_enable_next;
            bank_select <= bank_select_next;
            fire_pend   <= fire_next;
            state       <= ST_DIV;
          end
        end
        ST_DIV, ST_HOLD: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end else if (div_done || state == ST_HOLD) begin
            state <= ST_HOLD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the scanline IRQ counter and bank mapper. A directed table runs
// first, then random CPU writes and scanline ticks under many page counts. Depends on scim_pkg,
// scim_if.sv and the top level of the block.
module tb_top;
  import scim_pkg::*;

  typedef struct packed {
    logic                 req_type;
    logic [AddrWidth-1:0] addr;
    logic [DataWidth-1:0] data;
  } req_item_t;

  typedef struct packed {
    logic                    irq_fire;
    logic [SlotWidth-1:0]    page_low_slot;
    logic [SlotWidth-1:0]    page_high_slot;
    logic [CounterWidth-1:0] counter_now;
  } mapper_result_t;

  typedef struct packed {
    req_item_t      item;
    logic           typed;
    mapper_result_t want;
  } dir_row_t;

  localparam logic [ApbAddrWidth-1:0] PageCountAddr = ApbAddrWidth'(4 * int'(RegPageCount));
  localparam int RandomPerPhase = 140;

  logic                    clk;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;

  scim_req_if req_ch ();
  scim_rsp_if rsp_ch ();

  scanline_irq_counter_bank_mapper_top DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // Mirror of the block's state, advanced in transfer order.
  logic [CounterWidth-1:0]   pred_count;
  logic                      pred_enable;
  logic [BankWidth-1:0]      pred_bank;
  logic [PageCountWidth-1:0] pred_pages;

  mapper_result_t pending_results[$];
  mapper_result_t oldest;

  int  mismatches;
  int  results_seen;
  int  fires_seen;
  int  reqs_sent;
  int  settings_used;
  bit  quiet;
  int  idle_rate;
  int  stall_rate;
  int  stall_left;

  logic [AddrWidth-1:0] nibble_addr [4] = '{AddrNibble0, AddrNibble1, AddrNibble2, AddrNibble3};
  logic [AddrWidth-1:0] reg_addr [6] =
    '{AddrNibble0, AddrNibble1, AddrNibble2, AddrNibble3, AddrEnable, AddrBank};

  // Directed table. Rows with typed set carry their result; the rest go to the predictor.
  dir_row_t dir_rows [24] = '{
    '{'{ReqTick,     16'h0000,    8'h00}, 1'b1, '{1'b0, 9'd0,  9'd1,  16'h0000}},
    '{'{ReqCpuWrite, AddrNibble0, 8'hFF}, 1'b1, '{1'b0, 9'd0,  9'd1,  16'h000F}},
    '{'{ReqCpuWrite, AddrNibble1, 8'hFF}, 1'b1, '{1'b0, 9'd0,  9'd1,  16'h00FF}},
    '{'{ReqCpuWrite, AddrNibble2, 8'hFF}, 1'b1, '{1'b0, 9'd0,  9'd1,  16'h0FFF}},
    '{'{ReqCpuWrite, AddrNibble3, 8'hFF}, 1'b1, '{1'b0, 9'd0,  9'd1,  16'hFFFF}},
    '{'{ReqCpuWrite, 16'h8001,    8'h55}, 1'b1, '{1'b0, 9'd0,  9'd1,  16'hFFFF}},
    '{'{ReqCpuWrite, 16'hFFFF,    8'h00}, 1'b1, '{1'b0, 9'd0,  9'd1,  16'hFFFF}},
    '{'{ReqCpuWrite, AddrEnable,  8'h02}, 1'b1, '{1'b0, 9'd0,  9'd1,  16'hFFFF}},
    '{'{ReqTick,     16'hFFFF,    8'hFF}, 1'b1, '{1'b1, 9'd0,  9'd1,  16'hFFFF}},
    '{'{ReqTick,     16'h0000,    8'h00}, 1'b1, '{1'b0, 9'd0,  9'd1,  16'hFFFF}},
    '{'{ReqCpuWrite, AddrNibble0, 8'h0D}, 1'b0, '0},
    '{'{ReqCpuWrite, AddrNibble1, 8'hF8}, 1'b0, '0},
    '{'{ReqCpuWrite, AddrNibble2, 8'h0F}, 1'b0, '0},
    '{'{ReqCpuWrite, AddrNibble3, 8'hAF}, 1'b0, '0},
    '{'{ReqCpuWrite, AddrEnable,  8'hFF}, 1'b0, '0},
    '{'{ReqTick,     16'h1234,    8'h56}, 1'b0, '0},
    '{'{ReqTick,     16'hC000,    8'h00}, 1'b0, '0},
    '{'{ReqCpuWrite, AddrEnable,  8'hFD}, 1'b0, '0},
    '{'{ReqTick,     16'h8000,    8'h0F}, 1'b0, '0},
    '{'{ReqCpuWrite, AddrBank,    8'hFF}, 1'b1, '{1'b0, 9'd14, 9'd15, 16'hFFFF}},
    '{'{ReqCpuWrite, AddrBank,    8'h00}, 1'b1, '{1'b0, 9'd0,  9'd1,  16'hFFFF}},
    '{'{ReqCpuWrite, AddrBank,    8'h07}, 1'b0, '0},
    '{'{ReqCpuWrite, 16'hE000,    8'hAA}, 1'b0, '0},
    '{'{ReqTick,     AddrBank,    8'h33}, 1'b0, '0}
  };

  always #4 clk = ~clk;

  function automatic req_item_t make_req(logic kind, logic [AddrWidth-1:0] a,
                                         logic [DataWidth-1:0] d);
    req_item_t it;
    it.req_type = kind;
    it.addr     = a;
    it.data     = d;
    return it;
  endfunction

  // Applies one request to the mirrored state and returns the result it must produce.
  function automatic mapper_result_t step_mapper(req_item_t it);
    mapper_result_t r;
    int unsigned    pages;
    int             shift;
    r.irq_fire = 1'b0;
    if (it.req_type == ReqCpuWrite) begin
      shift = -1;
      case (it.addr)
        AddrNibble0: shift = 0;
        AddrNibble1: shift = 4;
        AddrNibble2: shift = 8;
        AddrNibble3: shift = 12;
        AddrEnable:  pred_enable = it.data[EnableBit];
        AddrBank:    pred_bank = it.data;
        default: ;
      endcase
      if (shift >= 0) begin
        pred_count = (pred_count & ~(16'hF << shift)) | (CounterWidth'(it.data[3:0]) << shift);
      end
    end else if (pred_enable) begin
      if (pred_count > FireLimit) begin
        r.irq_fire  = 1'b1;
        pred_enable = 1'b0;
      end else begin
        pred_count = pred_count + TickStep;
      end
    end
    pages = (pred_pages == '0) ? 1 : int'(pred_pages);
    r.page_low_slot  = SlotWidth'((2 * int'(pred_bank)) % pages);
    r.page_high_slot = SlotWidth'((2 * int'(pred_bank) + 1) % pages);
    r.counter_now    = pred_count;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Presents one request and holds it until its transfer. The predicted result is queued now,
  // which keeps it in transfer order since requests go out one at a time.
  task automatic send_req(req_item_t it, bit use_typed = 1'b0, mapper_result_t typed_res = '0);
    mapper_result_t r;
    int             gap;
    r = step_mapper(it);
    if (!quiet && idle_rate != 0 && $urandom_range(0, 15) < 2 * idle_rate) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    pending_results.push_back(use_typed ? typed_res : r);
    @(negedge clk);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= it.req_type;
    req_ch.addr     <= it.addr;
    req_ch.data     <= it.data;
    do @(posedge clk); while (!req_ch.ready);
    reqs_sent++;
  endtask

  // Drops valid, then waits until every queued result has come back.
  task automatic drain;
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_page_count(logic [PageCountWidth-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PageCountAddr;
    pwdata  <= ApbDataWidth'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pred_pages = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("page_count readback", value, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  // Random traffic for one page count setting. Most of it loads the counter, often close to
  // the fire point, enables it and ticks; the rest is bank selects, single writes and noise.
  task automatic random_phase(int quota);
    int counted;
    int pick;
    int start;
    int n;
    logic [DataWidth-1:0] d;
    counted = 0;
    while (counted < quota) begin
      pick = $urandom_range(0, 99);
      if (pick % 25 == 0) begin
        idle_rate  = $urandom_range(0, 3);
        stall_rate = $urandom_range(0, 3);
      end
      if (pick < 40) begin
        start = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
          n = (start + k) % 4;
          d = DataWidth'($urandom_range(0, 255));
          if (n >= 2 && $urandom_range(0, 1)) d[3:0] = 4'hF;
          send_req(make_req(ReqCpuWrite, nibble_addr[n], d));
        end
        d = DataWidth'($urandom_range(0, 255));
        d[EnableBit] = ($urandom_range(0, 7) != 0);
        send_req(make_req(ReqCpuWrite, AddrEnable, d));
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
          send_req(make_req(ReqTick, AddrWidth'($urandom_range(0, 65535)),
                            DataWidth'($urandom_range(0, 255))));
        end
        counted += 5 + n;
      end else if (pick < 60) begin
        send_req(make_req(ReqCpuWrite, AddrBank, DataWidth'($urandom_range(0, 255))));
        send_req(make_req(ReqTick, AddrWidth'($urandom_range(0, 65535)),
                          DataWidth'($urandom_range(0, 255))));
        counted += 2;
      end else if (pick < 85) begin
        if ($urandom_range(0, 2) == 0) begin
          send_req(make_req(ReqTick, AddrWidth'($urandom_range(0, 65535)),
                            DataWidth'($urandom_range(0, 255))));
        end else begin
          send_req(make_req(ReqCpuWrite, reg_addr[$urandom_range(0, 5)],
                            DataWidth'($urandom_range(0, 255))));
        end
        counted++;
      end else if (pick < 93) begin
        // Near miss: a register address with one bit flipped.
        send_req(make_req(ReqCpuWrite,
                          reg_addr[$urandom_range(0, 5)] ^ (16'h1 << $urandom_range(0, 15)),
                          DataWidth'($urandom_range(0, 255))));
        counted++;
      end else begin
        send_req(make_req(ReqCpuWrite, AddrWidth'($urandom_range(0, 65535)),
                          DataWidth'($urandom_range(0, 255))));
        counted++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (!quiet && stall_rate != 0 && $urandom_range(0, 15) < 2 * stall_rate) begin
        stall_left <= $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got fire=%0d low=%0d high=%0d cnt=0x%0h",
                 $time, rsp_ch.irq_fire, rsp_ch.page_low_slot, rsp_ch.page_high_slot,
                 rsp_ch.counter_now);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("irq_fire", oldest.irq_fire, rsp_ch.irq_fire);
        check_field("page_low_slot", oldest.page_low_slot, rsp_ch.page_low_slot);
        check_field("page_high_slot", oldest.page_high_slot, rsp_ch.page_high_slot);
        check_field("counter_now", oldest.counter_now, rsp_ch.counter_now);
        results_seen++;
        if (oldest.irq_fire) fires_seen++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned page_plan [10];
    clk             = 1'b0;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = ReqCpuWrite;
    req_ch.addr     = '0;
    req_ch.data     = '0;
    rsp_ch.ready    = 1'b0;
    stall_left      = 0;
    quiet           = 1'b0;
    idle_rate       = 1;
    stall_rate      = 1;
    mismatches      = 0;
    results_seen    = 0;
    fires_seen      = 0;
    reqs_sent       = 0;
    settings_used   = 1;
    pred_count      = '0;
    pred_enable     = 1'b0;
    pred_bank       = '0;
    pred_pages      = PageCountReset;
    // Extremes, zero, out-of-range values and a few random in-range ones.
    page_plan = '{2, 512, 0, 1, 513, 1023, 3, $urandom_range(2, 512),
                  $urandom_range(2, 512), 16};
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_req(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    random_phase(RandomPerPhase / 2);
    drain();

    foreach (page_plan[p]) begin
      set_page_count(PageCountWidth'(page_plan[p]));
      // Bank select is kept across the change, so the first results show the new page count.
      send_req(make_req(ReqTick, AddrWidth'($urandom_range(0, 65535)),
                        DataWidth'($urandom_range(0, 255))));
      if (p == 9) quiet = 1'b1;
      random_phase(RandomPerPhase);
      drain();
    end

    repeat (30) @(posedge clk);
    $display("Sent %0d requests under %0d page count settings.", reqs_sent, settings_used);
    $display("Checked %0d results, %0d of them with the IRQ raised.", results_seen, fires_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
